FILE: rtl/dlws_pkg.sv
// ----------------------------------------------------------------------------
// dlws_pkg
// Shared types and constants of the day level window store.
// ----------------------------------------------------------------------------
package dlws_pkg;

  localparam int DEPTH_DEFAULT     = 512;
  localparam int LEVEL_MAX_DEFAULT = 4;

  localparam int DAY_W        = 31;
  localparam int LEVEL_IN_W   = 8;
  localparam int LEVEL_W      = 3;
  localparam int COUNT_W      = 32;
  localparam int LAST_W       = 32;
  localparam int FILLED_OUT_W = 10;
  localparam int REJECT_W     = 16;
  localparam int CFG_IDX_W    = 1;

  // Level code of a slot that is inside the window but not yet filled.
  localparam logic [LEVEL_W-1:0] UNKNOWN_LEVEL = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DAY = 1'b1;

  typedef enum logic [0:0] {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PLAN,
    S_WALK,
    S_SLOT_RD,
    S_SLOT_WR,
    S_RD_WAIT,
    S_OUT
  } state_t;

endpackage

FILE: rtl/dlws_ram.sv
// ----------------------------------------------------------------------------
// dlws_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module dlws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/dlws_seq.sv
// ----------------------------------------------------------------------------
// dlws_seq
// Sequencer and bookkeeping of the window: limit checks, window growth, the
// walk that marks newly covered slots unknown, and read-modify-write of a slot.
// ----------------------------------------------------------------------------
module dlws_seq
  import dlws_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEFAULT,
  parameter int LEVEL_MAX = LEVEL_MAX_DEFAULT,
  localparam int AW       = $clog2(DEPTH),
  localparam int CW       = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [0:0]              opcode,
  input  logic [DAY_W-1:0]        day,
  input  logic [LEVEL_IN_W-1:0]   level,
  input  logic [COUNT_W-1:0]      count,
  input  logic [DAY_W-1:0]        min_day,
  input  logic [DAY_W-1:0]        max_day,
  output logic                    ram_we,
  output logic [AW-1:0]           ram_waddr,
  output logic [LEVEL_W-1:0]      ram_wdata,
  output logic                    ram_re,
  output logic [AW-1:0]           ram_raddr,
  input  logic [LEVEL_W-1:0]      ram_rdata,
  output logic                    result_valid,
  output logic                    accepted,
  output logic [LEVEL_W-1:0]      level_out,
  output logic [LAST_W-1:0]       last_day,
  output logic [FILLED_OUT_W-1:0] filled_days,
  output logic [COUNT_W-1:0]      count_total,
  output logic                    counts_complete,
  output logic [REJECT_W-1:0]     reject_total,
  output logic                    all_zero
);

  localparam logic [AW:0]       DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0]     DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0]     LAST_A  = AW'(DEPTH - 1);
  localparam logic [LEVEL_IN_W-1:0] LEVEL_LIM = LEVEL_IN_W'(LEVEL_MAX);

  // Store index arithmetic modulo DEPTH; both operands are at most DEPTH.
  function automatic logic [AW-1:0] wrap_add(input logic [AW:0] a, input logic [AW:0] b);
    logic [AW:0] s;
    s = a + b;
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] wrap_sub(input logic [AW:0] a, input logic [AW:0] b);
    logic [AW:0] s;
    s = a - b;
    if (a < b) begin
      s = s + DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  state_t state, state_next;

  opcode_t               op_r;
  logic [DAY_W-1:0]      day_r;
  logic [LEVEL_IN_W-1:0] level_r;
  logic [COUNT_W-1:0]    count_r;
  logic [DAY_W-1:0]      win_start;
  logic [CW-1:0]         win_span;
  logic [AW-1:0]         start_addr;
  logic                  lim_bad;
  logic                  below;
  logic                  beyond;
  logic [DAY_W-1:0]      day_gap;
  logic [AW-1:0]         walk_addr;
  logic [CW-1:0]         walk_left;
  logic [AW-1:0]         slot_addr;
  logic [CW-1:0]         filled;
  logic [COUNT_W-1:0]    total;
  logic                  counts_ok;
  logic [REJECT_W-1:0]   rejects;
  logic [CW-1:0]         nonzero;
  logic [LEVEL_W-1:0]    level_res;
  logic                  accepted_res;

  // Check stage values, computed from the captured item.
  logic             chk_lim_bad;
  logic             chk_below;
  logic [DAY_W-1:0] chk_dist;

  // Plan stage values.
  logic          empty;
  logic          fits_below;
  logic          fits_beyond;
  logic          read_hit;
  logic          put_reject;
  logic [AW-1:0] addr_fwd;
  logic [AW-1:0] addr_back;
  logic [AW-1:0] addr_end;
  logic [CW-1:0] day_gap_c;

  // Slot update values.
  logic           first_fill;
  logic           old_nonzero;
  logic [COUNT_W:0] sum_wide;

  assign chk_lim_bad = (day_r < min_day) || (day_r > max_day) || (level_r > LEVEL_LIM);
  assign chk_below   = day_r < win_start;
  assign chk_dist    = chk_below ? (win_start - day_r) : (day_r - win_start);

  assign empty       = (win_span == '0);
  assign day_gap_c   = day_gap[CW-1:0];
  assign fits_below  = day_gap <= DAY_W'(DEPTH_C - win_span);
  assign fits_beyond = day_gap < DAY_W'(DEPTH);
  assign addr_fwd    = wrap_add({1'b0, start_addr}, (AW + 1)'(day_gap[AW-1:0]));
  assign addr_back   = wrap_sub({1'b0, start_addr}, (AW + 1)'(day_gap[AW-1:0]));
  assign addr_end    = wrap_add({1'b0, start_addr}, (AW + 1)'(win_span));
  assign read_hit    = !empty && !below && !beyond;
  assign put_reject  = lim_bad || (!empty && below && !fits_below)
                       || (!empty && !below && beyond && !fits_beyond);

  assign first_fill  = (ram_rdata == UNKNOWN_LEVEL);
  assign old_nonzero = (ram_rdata != '0) && !first_fill;
  assign sum_wide    = {1'b0, total} + {1'b0, count_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = walk_addr;
    ram_wdata  = UNKNOWN_LEVEL;
    ram_re     = 1'b0;
    ram_raddr  = slot_addr;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_PLAN;
      end
      S_PLAN: begin
        if (op_r == OP_READ) begin
          if (read_hit) begin
            ram_re     = 1'b1;
            ram_raddr  = addr_fwd;
            state_next = S_RD_WAIT;
          end else begin
            state_next = S_OUT;
          end
        end else if (put_reject) begin
          state_next = S_OUT;
        end else if (empty || below || beyond) begin
          state_next = S_WALK;
        end else begin
          state_next = S_SLOT_RD;
        end
      end
      S_WALK: begin
        ram_we = 1'b1;
        if (walk_left == CW'(1)) begin
          state_next = S_SLOT_RD;
        end
      end
      S_SLOT_RD: begin
        ram_re     = 1'b1;
        state_next = S_SLOT_WR;
      end
      S_SLOT_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = slot_addr;
        ram_wdata  = level_r[LEVEL_W-1:0];
        state_next = S_OUT;
      end
      S_RD_WAIT: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Item capture, check results and result values; no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_r    <= opcode_t'(opcode);
        day_r   <= day;
        level_r <= level;
        count_r <= count;
      end
      S_CHECK: begin
        lim_bad <= chk_lim_bad;
        below   <= chk_below;
        day_gap <= chk_dist;
        beyond  <= chk_dist >= DAY_W'(win_span);
      end
      S_PLAN: begin
        accepted_res <= (op_r == OP_READ) || !put_reject;
        level_res    <= (op_r == OP_READ) ? UNKNOWN_LEVEL : '0;
        if (empty) begin
          walk_addr <= start_addr;
          walk_left <= CW'(1);
          slot_addr <= start_addr;
        end else if (below) begin
          walk_addr <= addr_back;
          walk_left <= day_gap_c;
          slot_addr <= addr_back;
        end else begin
          walk_addr <= addr_end;
          walk_left <= day_gap_c + CW'(1) - win_span;
          slot_addr <= addr_fwd;
        end
      end
      S_WALK: begin
        walk_addr <= (walk_addr == LAST_A) ? '0 : walk_addr + AW'(1);
        walk_left <= walk_left - CW'(1);
      end
      S_RD_WAIT: begin
        level_res <= ram_rdata;
      end
      default: begin
      end
    endcase
  end

  // Window and statistics state.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_start  <= '0;
      win_span   <= '0;
      start_addr <= '0;
      filled     <= '0;
      total      <= '0;
      counts_ok  <= 1'b1;
      rejects    <= '0;
      nonzero    <= '0;
    end else begin
      if (state == S_PLAN && op_r == OP_PUT) begin
        if (put_reject) begin
          if (rejects != '1) begin
            rejects <= rejects + REJECT_W'(1);
          end
        end else if (empty) begin
          win_start <= day_r;
          win_span  <= CW'(1);
        end else if (below) begin
          win_start  <= day_r;
          win_span   <= win_span + day_gap_c;
          start_addr <= addr_back;
        end else if (beyond) begin
          win_span <= day_gap_c + CW'(1);
        end
      end
      if (state == S_SLOT_WR) begin
        if (first_fill) begin
          filled <= filled + CW'(1);
          if (count_r[COUNT_W-1]) begin
            counts_ok <= 1'b0;
          end else begin
            total <= sum_wide[COUNT_W] ? '1 : sum_wide[COUNT_W-1:0];
          end
        end
        nonzero <= nonzero - CW'(old_nonzero) + CW'(level_r != '0);
      end
    end
  end

  assign busy            = (state != S_IDLE);
  assign result_valid    = (state == S_OUT);
  assign accepted        = accepted_res;
  assign level_out       = level_res;
  assign last_day        = empty ? '1 : (LAST_W'(win_start) + LAST_W'(win_span) - LAST_W'(1));
  assign filled_days     = FILLED_OUT_W'(filled);
  assign count_total     = total;
  assign counts_complete = counts_ok;
  assign reject_total    = rejects;
  assign all_zero        = (filled != '0) && (nonzero == '0);

endmodule

FILE: rtl/day_level_window_store.sv
// ----------------------------------------------------------------------------
// day_level_window_store
// Sliding window of per-day activity levels kept in one level memory.
// ----------------------------------------------------------------------------
// A put without window growth runs the check, plan, slot read, slot write and
// result states; a put that grows the window first walks each newly covered
// day (the unknown-marking walk uses the single memory write port, one slot a
// cycle). Reads inside the window add a read wait state; reads outside it and
// rejected puts go from plan to the result state. A new item is taken only when
// idle again. The result strobe is high one cycle and cannot be stalled. Reset
// empties the window and clears all counters; the memory needs no clearing pass.
module day_level_window_store
  import dlws_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEFAULT,
  parameter int LEVEL_MAX = LEVEL_MAX_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [0:0]              opcode,
  input  logic [DAY_W-1:0]        day,
  input  logic [LEVEL_IN_W-1:0]   level,
  input  logic [COUNT_W-1:0]      count,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DAY_W-1:0]        cfg_data,
  output logic                    result_valid,
  output logic                    accepted,
  output logic [LEVEL_W-1:0]      level_out,
  output logic [LAST_W-1:0]       last_day,
  output logic [FILLED_OUT_W-1:0] filled_days,
  output logic [COUNT_W-1:0]      count_total,
  output logic                    counts_complete,
  output logic [REJECT_W-1:0]     reject_total,
  output logic                    all_zero
);

  localparam int AW = $clog2(DEPTH);

  // Day limits for puts. A put outside [min_day, max_day] is rejected, so
  // crossed limits reject every put.
  logic [DAY_W-1:0] min_day;
  logic [DAY_W-1:0] max_day;

  // Memory port wires between the sequencer and the level store.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [LEVEL_W-1:0] ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [LEVEL_W-1:0] ram_rdata;

  // Configuration writes are taken in any cycle; the user must keep them to idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_day <= '0;
      max_day <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_DAY: min_day <= cfg_data;
        REG_MAX_DAY: max_day <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The sequencer keeps the window as a start day, a span and the memory
  // index of the start day. Slots of the window sit at consecutive indexes
  // modulo DEPTH, so every day in the window has a slot of its own.
  dlws_seq #(
    .DEPTH     (DEPTH),
    .LEVEL_MAX (LEVEL_MAX)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .day             (day),
    .level           (level),
    .count           (count),
    .min_day         (min_day),
    .max_day         (max_day),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata),
    .result_valid    (result_valid),
    .accepted        (accepted),
    .level_out       (level_out),
    .last_day        (last_day),
    .filled_days     (filled_days),
    .count_total     (count_total),
    .counts_complete (counts_complete),
    .reject_total    (reject_total),
    .all_zero        (all_zero)
  );

  // Level store: one 3-bit code per slot, unknown marked as code 7. Every
  // slot is written as unknown when it enters the window, so no read ever
  // sees an unwritten entry.
  dlws_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (DEPTH)
  ) u_level_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: verif/day_level_window_store_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// day_level_window_store_checker
// Watches the command, configuration and result channels of the day level
// window store. It keeps its own copy of the window and predicts each result.
// ----------------------------------------------------------------------------
module day_level_window_store_checker
  import dlws_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEFAULT,
  parameter int LEVEL_MAX = LEVEL_MAX_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [0:0]              opcode,
  input  logic [DAY_W-1:0]        day,
  input  logic [LEVEL_IN_W-1:0]   level,
  input  logic [COUNT_W-1:0]      count,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DAY_W-1:0]        cfg_data,
  input  logic                    result_valid,
  input  logic                    accepted,
  input  logic [LEVEL_W-1:0]      level_out,
  input  logic [LAST_W-1:0]       last_day,
  input  logic [FILLED_OUT_W-1:0] filled_days,
  input  logic [COUNT_W-1:0]      count_total,
  input  logic                    counts_complete,
  input  logic [REJECT_W-1:0]     reject_total,
  input  logic                    all_zero,
  output int                      mismatch_count,
  output int                      pending_results
);

  typedef struct packed {
    logic                    accepted;
    logic [LEVEL_W-1:0]      level_out;
    logic [LAST_W-1:0]       last_day;
    logic [FILLED_OUT_W-1:0] filled_days;
    logic [COUNT_W-1:0]      count_total;
    logic                    counts_complete;
    logic [REJECT_W-1:0]     reject_total;
    logic                    all_zero;
  } day_report_t;

  day_report_t        expected_reports[$];
  logic [LEVEL_W-1:0] slot_level[DEPTH];
  int unsigned        win_start;
  int unsigned        win_span;
  int unsigned        filled;
  int unsigned        nonzero_slots;
  int unsigned        lo_limit;
  int unsigned        hi_limit;
  logic [COUNT_W-1:0] count_sum;
  logic               counts_whole;
  logic [REJECT_W-1:0] reject_sum;
  int                 faults;

  function automatic void bump_rejects();
    if (reject_sum != '1) reject_sum++;
  endfunction

  function automatic void mark_unknown(int unsigned first, int unsigned n);
    for (int unsigned k = 0; k < n; k++) slot_level[(first + k) % DEPTH] = UNKNOWN_LEVEL;
  endfunction

  // Grows the window as needed and stores the level; returns 0 on rejection.
  function automatic bit apply_put(int unsigned d, int unsigned lvl, logic [COUNT_W-1:0] cnt);
    int unsigned       gap;
    int unsigned       idx;
    logic [COUNT_W:0]  grown;
    if (d < lo_limit || d > hi_limit || lvl > LEVEL_MAX) begin
      bump_rejects();
      return 1'b0;
    end
    if (win_span == 0) begin
      win_start = d;
      win_span  = 1;
      mark_unknown(d, 1);
    end else if (d < win_start) begin
      gap = win_start - d;
      if (win_span + gap > DEPTH) begin
        bump_rejects();
        return 1'b0;
      end
      mark_unknown(d, gap);
      win_start = d;
      win_span += gap;
    end else if (d - win_start >= win_span) begin
      gap = d - win_start + 1;
      if (gap > DEPTH) begin
        bump_rejects();
        return 1'b0;
      end
      mark_unknown(win_start + win_span, gap - win_span);
      win_span = gap;
    end
    idx = d % DEPTH;
    if (slot_level[idx] == UNKNOWN_LEVEL) begin
      filled++;
      if (cnt[COUNT_W-1]) begin
        counts_whole = 1'b0;
      end else begin
        grown     = {1'b0, count_sum} + {1'b0, cnt};
        count_sum = grown[COUNT_W] ? '1 : grown[COUNT_W-1:0];
      end
    end else if (slot_level[idx] != 0) begin
      nonzero_slots--;
    end
    if (lvl != 0) nonzero_slots++;
    slot_level[idx] = lvl[LEVEL_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic [LEVEL_W-1:0] look_up(int unsigned d);
    if (win_span == 0 || d < win_start || d - win_start >= win_span) return UNKNOWN_LEVEL;
    return slot_level[d % DEPTH];
  endfunction

  function automatic day_report_t predict_report(logic [0:0] op, int unsigned d,
                                                 int unsigned lvl, logic [COUNT_W-1:0] cnt);
    day_report_t r;
    r.level_out = '0;
    if (op == OP_READ) begin
      r.accepted  = 1'b1;
      r.level_out = look_up(d);
    end else begin
      r.accepted = apply_put(d, lvl, cnt);
    end
    r.last_day        = (win_span != 0) ? win_start + win_span - 1 : '1;
    r.filled_days     = filled[FILLED_OUT_W-1:0];
    r.count_total     = count_sum;
    r.counts_complete = counts_whole;
    r.reject_total    = reject_sum;
    r.all_zero        = (filled != 0 && nonzero_slots == 0);
    return r;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      faults++;
      if (faults <= 10)
        $display("%0t ns: MISMATCH in %s, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    day_report_t want;
    if (rst) begin
      expected_reports.delete();
      win_start     = 0;
      win_span      = 0;
      filled        = 0;
      nonzero_slots = 0;
      lo_limit      = 0;
      hi_limit      = 32'h7FFF_FFFF;
      count_sum     = '0;
      counts_whole  = 1'b1;
      reject_sum    = '0;
    end else begin
      if (result_valid) begin
        if (expected_reports.size() == 0) begin
          faults++;
          if (faults <= 10) $display("%0t ns: MISMATCH, result beat with none expected", $time);
        end else begin
          want = expected_reports.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(accepted));
          check_field("level_out", 32'(want.level_out), 32'(level_out));
          check_field("last_day", want.last_day, last_day);
          check_field("filled_days", 32'(want.filled_days), 32'(filled_days));
          check_field("count_total", want.count_total, count_total);
          check_field("counts_complete", 32'(want.counts_complete), 32'(counts_complete));
          check_field("reject_total", 32'(want.reject_total), 32'(reject_total));
          check_field("all_zero", 32'(want.all_zero), 32'(all_zero));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_DAY: lo_limit = 32'(cfg_data);
          REG_MAX_DAY: hi_limit = 32'(cfg_data);
          default: ;
        endcase
      end
      if (start && !busy)
        expected_reports.push_back(predict_report(opcode, 32'(day), 32'(level), count));
    end
    pending_results <= expected_reports.size();
    mismatch_count  <= faults;
  end

endmodule

FILE: verif/day_level_window_store_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// day_level_window_store_tb
// Drives puts, reads and limit writes into the day level window store. A
// checker beside the block predicts every result beat and counts mismatches;
// this top makes the stimulus, runs the watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module day_level_window_store_tb;
  import dlws_pkg::*;

  localparam int DEPTH     = DEPTH_DEFAULT;
  localparam int LEVEL_MAX = LEVEL_MAX_DEFAULT;
  // Longest quiet stretch of a correct run is one full-depth walk plus a
  // sender gap; the limit allows several times that.
  localparam int QUIET_LIMIT = 4 * (DEPTH + 32);

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [0:0]              opcode;
  logic [DAY_W-1:0]        day;
  logic [LEVEL_IN_W-1:0]   level;
  logic [COUNT_W-1:0]      count;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [DAY_W-1:0]        cfg_data;
  logic                    result_valid;
  logic                    accepted;
  logic [LEVEL_W-1:0]      level_out;
  logic [LAST_W-1:0]       last_day;
  logic [FILLED_OUT_W-1:0] filled_days;
  logic [COUNT_W-1:0]      count_total;
  logic                    counts_complete;
  logic [REJECT_W-1:0]     reject_total;
  logic                    all_zero;

  int          mismatch_count;
  int          pending_results;
  int          quiet_cycles;
  int unsigned base_day;   // center of the window this run works around
  bit          steady;     // when set, the sender never idles between beats

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  day_level_window_store #(.DEPTH(DEPTH), .LEVEL_MAX(LEVEL_MAX)) DUT (.*);

  day_level_window_store_checker #(.DEPTH(DEPTH), .LEVEL_MAX(LEVEL_MAX)) checker_i (.*);

  // Watchdog: any command, configuration or result beat counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one command and holds it until the block takes the beat. Now and
  // then the sender first idles, so that the gaps land on various phases of the
  // block's work.
  task automatic issue_op(opcode_t op, int unsigned d, int unsigned lvl, logic [31:0] cnt);
    int gap;
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 10) begin
      gap   = $urandom_range(1, 12);
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  = 1'b1;
    opcode = op;
    day    = d[DAY_W-1:0];
    level  = lvl[LEVEL_IN_W-1:0];
    count  = cnt;
    do @(posedge clk); while (busy);
  endtask

  // Limits are only changed with no result outstanding, while the block is idle;
  // cfg_ready is tied high in the block.
  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    start = 1'b0;
    while (pending_results != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value[DAY_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic int unsigned near_day(int unsigned reach);
    return base_day - reach + $urandom_range(0, 2 * reach);
  endfunction

  // Mostly small known counts; sometimes unknown ones, -1 among them.
  function automatic logic [31:0] pick_count();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return $urandom_range(0, 5000);
    if (roll < 95) return $urandom | 32'h8000_0000;
    return 32'hFFFF_FFFF;
  endfunction

  // Traffic around the window: puts near the base day that grow it, some with
  // levels above the maximum, reads that straddle its ends, and random-field noise.
  task automatic random_phase(int items, int unsigned reach);
    int          roll;
    int unsigned lvl;
    logic [31:0] cnt;
    repeat (items) begin
      roll = $urandom_range(0, 99);
      cnt  = pick_count();
      if (roll < 60) begin
        lvl = ($urandom_range(0, 9) == 0) ? $urandom_range(LEVEL_MAX + 1, 255)
                                          : $urandom_range(0, LEVEL_MAX);
        issue_op(OP_PUT, near_day(reach), lvl, cnt);
      end else if (roll < 85) begin
        issue_op(OP_READ, near_day(reach + 8), $urandom_range(0, 255), cnt);
      end else begin
        issue_op(opcode_t'($urandom_range(0, 1)), $urandom, $urandom_range(0, 255), $urandom);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned far_end;
    rst       = 1'b1;
    start     = 1'b0;
    opcode    = OP_PUT;
    day       = '0;
    level     = '0;
    count     = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MIN_DAY;
    cfg_data  = '0;
    steady    = 1'b0;
    base_day  = $urandom_range(4096, 32'h7FFF_0000);
    far_end   = base_day - 200 + DEPTH - 1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Widest limits first, both registers at their extremes.
    write_limit(REG_MIN_DAY, 0);
    write_limit(REG_MAX_DAY, 32'h7FFF_FFFF);

    // Directed part. A read of the empty window answers unknown.
    issue_op(OP_READ, base_day, 0, 0);
    // The first put opens the window; a lone zero level sets the all-zero flag.
    issue_op(OP_PUT, base_day, 0, 10);
    issue_op(OP_READ, base_day, 0, 0);
    // Growth upward by three days at the level maximum.
    issue_op(OP_PUT, base_day + 3, LEVEL_MAX, 20);
    issue_op(OP_READ, base_day + 1, 0, 0);
    // Growth downward; a negative count other than -1 also means unknown.
    issue_op(OP_PUT, base_day - 2, 1, 32'h8000_0000);
    issue_op(OP_PUT, base_day + 1, 0, 32'hFFFF_FFFF);
    // Refills only change the level, whatever the count says.
    issue_op(OP_PUT, base_day + 3, 0, 32'h7FFF_FFFF);
    issue_op(OP_PUT, base_day - 2, 0, 5);
    // Levels above the maximum are rejected.
    issue_op(OP_PUT, base_day + 1, LEVEL_MAX + 1, 1);
    issue_op(OP_PUT, base_day + 1, 255, 1);
    // Days at both ends of the day range would stretch the window too far.
    issue_op(OP_PUT, 0, 2, 1);
    issue_op(OP_PUT, 32'h7FFF_FFFF, 2, 1);
    issue_op(OP_READ, 0, 0, 0);
    issue_op(OP_READ, 32'h7FFF_FFFF, 0, 0);
    issue_op(OP_READ, base_day - 3, 0, 0);
    issue_op(OP_READ, base_day + 4, 0, 0);

    // Random part, one setting of the limits per phase.
    random_phase(90, 40);

    // Narrow limits inside the window, with a long stretch of back-to-back beats.
    write_limit(REG_MIN_DAY, base_day - 30);
    write_limit(REG_MAX_DAY, base_day + 60);
    steady = 1'b1;
    random_phase(90, 80);
    steady = 1'b0;

    // Crossed limits: every put is rejected.
    write_limit(REG_MIN_DAY, base_day + 5);
    write_limit(REG_MAX_DAY, base_day - 5);
    random_phase(25, 60);

    // A single accepted day.
    write_limit(REG_MIN_DAY, base_day + 7);
    write_limit(REG_MAX_DAY, base_day + 7);
    random_phase(20, 20);

    write_limit(REG_MIN_DAY, base_day - 200);
    write_limit(REG_MAX_DAY, 32'h7FFF_FFFF);
    random_phase(110, 200);

    write_limit(REG_MIN_DAY, 0);
    random_phase(90, 200);

    // Closing items: fill the window to exactly its depth, try one day past
    // either end, then push the count total into saturation with first fills.
    issue_op(OP_PUT, base_day - 200, 1, 3);
    issue_op(OP_PUT, far_end, 2, 4);
    issue_op(OP_PUT, base_day - 201, 1, 1);
    issue_op(OP_PUT, far_end + 1, 1, 1);
    issue_op(OP_READ, far_end, 0, 0);
    issue_op(OP_READ, far_end + 1, 0, 0);
    issue_op(OP_PUT, far_end - 1, 3, 32'h7FFF_FFFF);
    issue_op(OP_PUT, far_end - 2, 3, 32'h7FFF_FFFF);
    issue_op(OP_PUT, far_end - 3, 3, 32'h7FFF_FFFF);
    issue_op(OP_PUT, far_end - 1, 0, 32'h7FFF_FFFF);

    @(negedge clk);
    start = 1'b0;
    while (pending_results != 0) @(negedge clk);
    // Leave room for a stray result beat from a late walk.
    repeat (DEPTH + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dlws_pkg.sv
rtl/dlws_ram.sv
rtl/dlws_seq.sv
rtl/day_level_window_store.sv
verif/day_level_window_store_checker.sv
verif/day_level_window_store_tb.sv
